/* hw/rtl/joystick_direction_repeat_unit_assert.svh */
// Assertion macros shared by the joystick direction repeat unit.
`ifndef JOYSTICK_DIRECTION_REPEAT_UNIT_ASSERT_SVH
`define JOYSTICK_DIRECTION_REPEAT_UNIT_ASSERT_SVH

// Check that expr holds in the same cycle as cond.
`define JDR_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("joystick unit: same-cycle check failed");

// Check that expr holds in the cycle after cond.
`define JDR_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("joystick unit: next-cycle check failed");

`endif

/* hw/rtl/jdr_pkg.sv */
`default_nettype none

package jdr_pkg;

    // Sample width default and fixed field widths
    localparam int SAMPLE_BITS_DEFAULT = 12;
    localparam int REPEAT_BITS         = 16;
    localparam int TIME_BITS           = 32;
    localparam int CFG_DATA_BITS       = 16;
    localparam int CFG_INDEX_BITS      = 2;

    // Register reset values
    localparam int                     DEADZONE_RESET = 400;
    localparam logic [REPEAT_BITS-1:0] REPEAT_RESET   = 16'd200;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_DEADZONE = 2'd2,
        REG_REPEAT   = 2'd3
    } cfg_index_t;

    // Direction codes
    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_t;

endpackage

`default_nettype wire

/* hw/rtl/joystick_direction_repeat_unit.sv */
// Joystick direction repeat unit: takes one poll per clock unless in_stall is high (two stick
// samples, the active-low button level and a millisecond time stamp) and returns one result
// per poll with the decoded direction, a direction event (on a new direction or after the
// repeat interval has elapsed), the button state and a press event. The poll lands in an
// input register, the decode, deadzone compares and 32-bit elapsed-time compare run in one
// combinational stage, and the result is held in an output register. The state (previous
// direction, last event time, previous button) is updated in the same cycle an item moves
// from the input register to the output register. The user must write centers, deadzone and
// repeat interval through the cfg port while no poll is in flight; the block does not check it.
`default_nettype none

`include "joystick_direction_repeat_unit_assert.svh"

module joystick_direction_repeat_unit #(
    parameter int SAMPLE_BITS = jdr_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_write,
    input  wire logic [jdr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [jdr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // poll channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [SAMPLE_BITS-1:0]              x_sample,
    input  wire logic [SAMPLE_BITS-1:0]              y_sample,
    input  wire logic                                button_level,
    input  wire logic [jdr_pkg::TIME_BITS-1:0]       time_ms,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [2:0]                               direction,
    output logic [2:0]                               direction_event,
    output logic                                     button_down,
    output logic                                     button_event
);

    localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] DZ_RESET     = SAMPLE_BITS'(jdr_pkg::DEADZONE_RESET);

    // Configuration registers
    logic [SAMPLE_BITS-1:0]          center_x_reg;
    logic [SAMPLE_BITS-1:0]          center_y_reg;
    logic [SAMPLE_BITS-1:0]          deadzone_reg;
    logic [jdr_pkg::REPEAT_BITS-1:0] repeat_reg;

    // Input stage
    logic                            s1_valid_reg;
    logic [SAMPLE_BITS-1:0]          s1_x_reg;
    logic [SAMPLE_BITS-1:0]          s1_y_reg;
    logic                            s1_level_reg;
    logic [jdr_pkg::TIME_BITS-1:0]   s1_time_reg;

    // Poll-to-poll state
    jdr_pkg::dir_t                   prev_dir_reg;
    logic [jdr_pkg::TIME_BITS-1:0]   last_time_reg;
    logic                            prev_button_reg;

    // Output stage
    logic                            out_valid_reg;
    jdr_pkg::dir_t                   dir_out_reg;
    jdr_pkg::dir_t                   dev_out_reg;
    logic                            down_out_reg;
    logic                            bev_out_reg;

    logic                            s2_load;
    logic                            s1_load;

    logic signed [SAMPLE_BITS:0]     dx;
    logic signed [SAMPLE_BITS:0]     dy;
    logic signed [SAMPLE_BITS+1:0]   dx_w;
    logic signed [SAMPLE_BITS+1:0]   dy_w;
    logic signed [SAMPLE_BITS+1:0]   dz_w;
    logic [jdr_pkg::TIME_BITS-1:0]   elapsed;
    logic                            interval_done;
    logic                            down_next;
    logic                            bev_next;
    jdr_pkg::dir_t                   dir_next;
    jdr_pkg::dir_t                   dev_next;

    // Handshake: output register frees when empty or taken, input stage follows
    assign s2_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_load  = in_valid && !in_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_RESET;
            center_y_reg <= CENTER_RESET;
            deadzone_reg <= DZ_RESET;
            repeat_reg   <= jdr_pkg::REPEAT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (jdr_pkg::cfg_index_t'(cfg_index))
                jdr_pkg::REG_CENTER_X: center_x_reg <= cfg_data[SAMPLE_BITS-1:0];
                jdr_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[SAMPLE_BITS-1:0];
                jdr_pkg::REG_DEADZONE: deadzone_reg <= cfg_data[SAMPLE_BITS-1:0];
                jdr_pkg::REG_REPEAT:   repeat_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the poll into the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_x_reg     <= x_sample;
            s1_y_reg     <= y_sample;
            s1_level_reg <= button_level;
            s1_time_reg  <= time_ms;
        end
    end

    // Offsets from center, sign-extended for the deadzone compares
    assign dx   = $signed({1'b0, s1_x_reg}) - $signed({1'b0, center_x_reg});
    assign dy   = $signed({1'b0, s1_y_reg}) - $signed({1'b0, center_y_reg});
    assign dx_w = {dx[SAMPLE_BITS], dx};
    assign dy_w = {dy[SAMPLE_BITS], dy};
    assign dz_w = $signed({2'b00, deadzone_reg});

    // Elapsed time since the last event, modulo 2^32
    assign elapsed       = s1_time_reg - last_time_reg;
    assign interval_done = elapsed >= {{(jdr_pkg::TIME_BITS - jdr_pkg::REPEAT_BITS){1'b0}},
                                       repeat_reg};

    // Decode direction in priority up, down, left, right and raise events
    always_comb
    begin
        if (dy_w < -dz_w)
        begin
            dir_next = jdr_pkg::DIR_UP;
        end
        else if (dy_w > dz_w)
        begin
            dir_next = jdr_pkg::DIR_DOWN;
        end
        else if (dx_w < -dz_w)
        begin
            dir_next = jdr_pkg::DIR_LEFT;
        end
        else if (dx_w > dz_w)
        begin
            dir_next = jdr_pkg::DIR_RIGHT;
        end
        else
        begin
            dir_next = jdr_pkg::DIR_NONE;
        end

        if (dir_next != jdr_pkg::DIR_NONE && (dir_next != prev_dir_reg || interval_done))
        begin
            dev_next = dir_next;
        end
        else
        begin
            dev_next = jdr_pkg::DIR_NONE;
        end

        down_next = !s1_level_reg;
        bev_next  = down_next && !prev_button_reg;
    end

    // Advance poll-to-poll state as the item leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_dir_reg    <= jdr_pkg::DIR_NONE;
            last_time_reg   <= '0;
            prev_button_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            prev_dir_reg    <= dir_next;
            prev_button_reg <= down_next;
            if (dev_next != jdr_pkg::DIR_NONE)
            begin
                last_time_reg <= s1_time_reg;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            dir_out_reg  <= dir_next;
            dev_out_reg  <= dev_next;
            down_out_reg <= down_next;
            bev_out_reg  <= bev_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign direction       = dir_out_reg;
    assign direction_event = dev_out_reg;
    assign button_down     = down_out_reg;
    assign button_event    = bev_out_reg;

    // Checks
    `JDR_ASSERT_NOW(a_event_matches_dir, out_valid_reg,
        dev_out_reg == jdr_pkg::DIR_NONE || dev_out_reg == dir_out_reg)
    `JDR_ASSERT_NOW(a_press_implies_down, out_valid_reg && bev_out_reg, down_out_reg)
    `JDR_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid_reg && out_valid_reg)
    `JDR_ASSERT_NEXT(a_event_time_kept, s2_load && dev_next != jdr_pkg::DIR_NONE,
        last_time_reg == $past(s1_time_reg))

endmodule

`default_nettype wire
